/* design/zrs_pkg.sv */
// ----------------------------------------------------------------------------
// zrs_pkg
// Shared types and constants for the Zipf rank sampler: beat structs,
// opcodes, field widths and generator constants.
// ----------------------------------------------------------------------------
package zrs_pkg;

	localparam int RANK_W        = 11;
	localparam int WEIGHT_W      = 32;
	localparam int LCG_W         = 31;
	localparam int OPCODE_W      = 2;
	localparam int MAX_RANKS_DEF = 1024;
	localparam int CHUNK_W       = 16;

	localparam logic [OPCODE_W-1:0] OP_SEED = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_GEN  = 2'd2;

	localparam logic [14:0]      LCG_A     = 15'd16807;
	localparam logic [LCG_W-1:0] LCG_M     = 31'h7FFF_FFFF;
	localparam logic [RANK_W-1:0] RANK_RST = 11'd1024;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [RANK_W-1:0]   rank_index;
		logic [WEIGHT_W-1:0] weight;
		logic [LCG_W-1:0]    seed_value;
	} in_beat_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [LCG_W-1:0]  uniform;
	} out_beat_t;

endpackage

/* design/zrs_ram.sv */
// ----------------------------------------------------------------------------
// zrs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module zrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/zipf_rank_sampler_unit.sv */
// Config beats are taken only while idle.
// A generate beat steps the generator, runs a sum pass over the n active ranks when the total is stale,
// multiplies the total by the new generator state in NCH 16-bit slices, then searches; the
// weight RAM read port (one entry a cycle) serves both the sum pass and the search.
// One beat is worked at a time; a finished result waits in the output register.
// Reset: generator state 1, rank_count 1024, total stale; weight RAM not cleared.
// ----------------------------------------------------------------------------
// zipf_rank_sampler_unit
// Inverse-CDF Zipf rank sampler over a weight table in RAM, driven by a
// minimal-standard multiplicative congruential generator.
// ----------------------------------------------------------------------------
module zipf_rank_sampler_unit #(
	parameter int MAX_RANKS = zrs_pkg::MAX_RANKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [zrs_pkg::RANK_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  zrs_pkg::in_beat_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output zrs_pkg::out_beat_t             out_data
);
	import zrs_pkg::*;

	localparam int AW    = $clog2(MAX_RANKS);
	localparam int CNT_W = $clog2(MAX_RANKS + 1);
	localparam int SUM_W = WEIGHT_W + CNT_W;
	localparam int NCH   = (SUM_W + CHUNK_W - 1) / CHUNK_W;
	localparam int TP_W  = NCH * CHUNK_W;
	localparam int PW    = TP_W + LCG_W;
	localparam int LW    = SUM_W + LCG_W;
	localparam int MC_W  = $clog2(NCH + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LCG, ST_FOLD, ST_SUM, ST_MUL, ST_SEARCH, ST_DONE
	} state_t;

	state_t                   state_q;
	logic [RANK_W-1:0]        rank_count_q;
	logic [LCG_W-1:0]         lcg_q;
	logic [45:0]              lcg_prod_s1;
	logic                     total_valid_q;
	logic [SUM_W-1:0]         total_q;
	logic [SUM_W-1:0]         acc_q;
	logic [CNT_W-1:0]         rd_cnt_q;
	logic                     rd_v_s1;
	logic [AW-1:0]            idx_s1;
	logic                     v_s2;
	logic [AW-1:0]            idx_s2;
	logic                     v_s3;
	logic [AW-1:0]            idx_s3;
	logic [LW-1:0]            lhs_s3;
	logic [TP_W-1:0]          tot_sh_q;
	logic [MC_W-1:0]          mul_cnt_q;
	logic                     mul_v_s1;
	logic [CHUNK_W+LCG_W-1:0] mul_prod_s1;
	logic [PW-1:0]            prod_q;
	logic [RANK_W-1:0]        rank_q;
	logic                     out_valid_q;
	out_beat_t                out_data_q;

	logic [CNT_W-1:0]    n_act;
	logic                rd_issue;
	logic [WEIGHT_W-1:0] rdata;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic                load_ok;
	logic [31:0]         fold;
	logic [LCG_W-1:0]    lcg_next;
	logic                found;
	logic                in_fire;
	logic                out_load;

	// clamp of the rank count register
	always_comb begin
		if (rank_count_q == '0) begin
			n_act = CNT_W'(1);
		end else if (32'(rank_count_q) > MAX_RANKS) begin
			n_act = CNT_W'(MAX_RANKS);
		end else begin
			n_act = CNT_W'(rank_count_q);
		end
	end

	assign in_fire   = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign load_ok   = (in_data.rank_index != '0) && (32'(in_data.rank_index) <= MAX_RANKS);
	assign ram_we    = in_fire && (in_data.opcode == OP_LOAD) && load_ok;
	assign ram_waddr = AW'(in_data.rank_index - RANK_W'(1));

	assign rd_issue = ((state_q == ST_SUM) || (state_q == ST_SEARCH)) && (rd_cnt_q < n_act);

	// x * 16807 mod (2^31 - 1) by folding the Mersenne modulus
	assign fold     = 32'(lcg_prod_s1[30:0]) + 32'(lcg_prod_s1[45:31]);
	assign lcg_next = (fold >= 32'(LCG_M)) ? LCG_W'(fold - 32'(LCG_M)) : LCG_W'(fold);

	// acc * (2^31 - 1) >= total * x, or the last active rank
	assign found = v_s3 && ((PW'(lhs_s3) >= prod_q) || (idx_s3 == AW'(n_act - CNT_W'(1))));

	zrs_ram #(
		.WIDTH(WEIGHT_W),
		.DEPTH(MAX_RANKS)
	) u_weight_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(in_data.weight),
		.raddr(rd_cnt_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rank_count_q  <= RANK_RST;
			lcg_q         <= LCG_W'(1);
			lcg_prod_s1   <= '0;
			total_valid_q <= 1'b0;
			total_q       <= '0;
			acc_q         <= '0;
			rd_cnt_q      <= '0;
			rd_v_s1       <= 1'b0;
			idx_s1        <= '0;
			v_s2          <= 1'b0;
			idx_s2        <= '0;
			v_s3          <= 1'b0;
			idx_s3        <= '0;
			lhs_s3        <= '0;
			tot_sh_q      <= '0;
			mul_cnt_q     <= '0;
			mul_v_s1      <= 1'b0;
			mul_prod_s1   <= '0;
			prod_q        <= '0;
			rank_q        <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rank_count_q <= cfg_data;
			end
			// a new count or a new weight makes the total stale
			if ((cfg_valid && cfg_ready) || ram_we) begin
				total_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// read pipeline, shared by the sum pass and the search
			rd_v_s1 <= rd_issue;
			idx_s1  <= rd_cnt_q[AW-1:0];
			if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			if (rd_v_s1) begin
				acc_q <= acc_q + SUM_W'(rdata);
			end
			v_s2   <= rd_v_s1 && (state_q == ST_SEARCH);
			idx_s2 <= idx_s1;
			v_s3   <= v_s2 && (state_q == ST_SEARCH);
			idx_s3 <= idx_s2;
			lhs_s3 <= (LW'(acc_q) << LCG_W) - LW'(acc_q);

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (in_data.opcode)
							OP_SEED: begin
								if (in_data.seed_value != '0 && in_data.seed_value != LCG_M) begin
									lcg_q <= in_data.seed_value;
								end
							end
							OP_LOAD: begin
								// RAM write and stale mark happen above
							end
							OP_GEN: begin
								state_q <= ST_LCG;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LCG: begin
					lcg_prod_s1 <= 46'(lcg_q) * 46'(LCG_A);
					state_q     <= ST_FOLD;
				end
				ST_FOLD: begin
					lcg_q     <= lcg_next;
					acc_q     <= '0;
					rd_cnt_q  <= '0;
					tot_sh_q  <= TP_W'(total_q);
					mul_cnt_q <= '0;
					prod_q    <= '0;
					state_q   <= total_valid_q ? ST_MUL : ST_SUM;
				end
				ST_SUM: begin
					if (rd_cnt_q == n_act && !rd_v_s1) begin
						total_q       <= acc_q;
						total_valid_q <= 1'b1;
						tot_sh_q      <= TP_W'(acc_q);
						state_q       <= ST_MUL;
					end
				end
				ST_MUL: begin
					// total * x, one 16-bit slice a cycle, top slice first
					mul_v_s1 <= (mul_cnt_q != MC_W'(NCH));
					mul_prod_s1 <= (CHUNK_W+LCG_W)'(tot_sh_q[TP_W-1 -: CHUNK_W])
					             * (CHUNK_W+LCG_W)'(lcg_q);
					if (mul_cnt_q != MC_W'(NCH)) begin
						mul_cnt_q <= mul_cnt_q + MC_W'(1);
						tot_sh_q  <= tot_sh_q << CHUNK_W;
					end
					if (mul_v_s1) begin
						prod_q <= (prod_q << CHUNK_W) + PW'(mul_prod_s1);
					end
					if (mul_cnt_q == MC_W'(NCH) && !mul_v_s1) begin
						acc_q    <= '0;
						rd_cnt_q <= '0;
						state_q  <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (found) begin
						rank_q  <= RANK_W'(CNT_W'(idx_s3) + CNT_W'(1));
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_data_q.rank    <= rank_q;
						out_data_q.uniform <= lcg_q;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_ram_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("weight RAM written outside idle");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (rd_cnt_q < n_act))
		else $error("weight read beyond active ranks");

	a_total_before_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> total_valid_q)
		else $error("total used while stale");

	a_lcg_nonstuck: assert property (@(posedge clk) disable iff (!arst_n)
		(lcg_q != '0) && (lcg_q != LCG_M))
		else $error("generator state stuck");

	a_rank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (out_data_q.rank != '0))
		else $error("rank zero delivered");

endmodule
